[hw/rtl/mcfir_pkg.sv]
// ----------------------------------------------------------------------------
// mcfir_pkg
// Shared constants, types and codes for the multichannel FIR filter.
// ----------------------------------------------------------------------------
package mcfir_pkg;

    // Block configuration
    localparam int CHANNELS    = 8;
    localparam int TAPS        = 32;
    localparam int SAMPLE_BITS = 16;

    // Working sample width: samples and coefficients are Q1.(SAMPLE_W-1)
    localparam int SAMPLE_W = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;

    // Fixed field widths of the item and result channels
    localparam int CH_W    = 3;
    localparam int TIDX_W  = 5;
    localparam int VALUE_W = 16;

    // Configuration port
    localparam int CFG_W   = 6;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = PADDR_W - 2;
    localparam logic [RIDX_W-1:0] REG_TAP_COUNT   = RIDX_W'(0);
    localparam logic [CFG_W-1:0]  TAP_COUNT_RESET = CFG_W'(32);

    // Derived widths
    localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int TAP_CNT_W = $clog2(TAPS + 1);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DL_DEPTH  = CHANNELS * TAPS;
    localparam int DL_AW     = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + TAP_CNT_W;

    typedef enum logic [0:0] {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND
    } seq_state_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic vld;
        logic use_data;
    } mac_ctrl_t;

endpackage

[hw/rtl/mcfir_item_if.sv]
// ----------------------------------------------------------------------------
// mcfir_item_if
// Valid/ready channel carrying sample and coefficient-load items.
// ----------------------------------------------------------------------------
interface mcfir_item_if;
    import mcfir_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [CH_W-1:0]     channel;
    logic [TIDX_W-1:0]   tap_index;
    logic signed [VALUE_W-1:0] value;
    logic                last_in_hop;

    modport source (
        output valid, opcode, channel, tap_index, value, last_in_hop,
        input  ready
    );

    modport sink (
        input  valid, opcode, channel, tap_index, value, last_in_hop,
        output ready
    );

endinterface

[hw/rtl/mcfir_result_if.sv]
// ----------------------------------------------------------------------------
// mcfir_result_if
// Valid/ready channel carrying filtered samples.
// ----------------------------------------------------------------------------
interface mcfir_result_if;
    import mcfir_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CH_W-1:0]           out_channel;
    logic signed [VALUE_W-1:0] filtered_sample;
    logic                      out_last_in_hop;

    modport source (
        output valid, out_channel, filtered_sample, out_last_in_hop,
        input  ready
    );

    modport sink (
        input  valid, out_channel, filtered_sample, out_last_in_hop,
        output ready
    );

endinterface

[hw/rtl/multichannel_fir_filter.sv]
// ----------------------------------------------------------------------------
// multichannel_fir_filter
// Direct-form FIR filter for several channels with one shared coefficient set.
// ----------------------------------------------------------------------------
// A sample transfer runs through its steps in order: acceptance, one issue per
// active tap through the single shared multiply-accumulate unit, emptying the
// read and product pipeline, and rounding with the load of the output register.
// With a tap count of zero a sample goes straight from acceptance to rounding.
// A coefficient load is taken without leaving the idle state. The block takes
// no new item while a sample is being filtered; a finished result waits in the
// output register without stopping the next transfer, but the rounding step of
// the following sample waits while that register holds a result not yet taken.
// Delay lines are circular buffers in one RAM, with a write pointer and a fill
// count per channel, so no clearing pass is needed after reset.
module multichannel_fir_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    mcfir_item_if.sink                    item,
    mcfir_result_if.source                result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcfir_pkg::PADDR_W-1:0] paddr,
    input  logic [mcfir_pkg::PDATA_W-1:0] pwdata,
    output logic [mcfir_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import mcfir_pkg::*;

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0]     tap_count;
    logic                 accept;
    logic                 chan_ok;
    logic                 tap_ok;
    logic                 filt_go;
    logic                 coef_wr;
    logic [CH_IDX_W-1:0]  item_chan;
    logic [TAP_W-1:0]     ptr_inc;
    logic [TAP_CNT_W-1:0] fill_inc;
    logic [TAP_CNT_W-1:0] n_eff;

    logic [TAP_W-1:0]     ptr_reg  [CHANNELS];
    logic [TAP_CNT_W-1:0] fill_reg [CHANNELS];
    logic [TAPS-1:0]      coef_vld_reg;

    logic [CH_IDX_W-1:0]  chan_reg;
    logic [CH_W-1:0]      chan_out_reg;
    logic                 last_reg;
    logic [TAP_W-1:0]     ptr_cur_reg;
    logic [TAP_CNT_W-1:0] fill_cur_reg;
    logic [TAP_CNT_W-1:0] n_reg;
    logic [TAP_CNT_W-1:0] k_reg, k_next;
    logic [TAP_W-1:0]     kidx;
    logic [TAP_W-1:0]     rd_idx;

    logic                 iss_vld_reg, iss_vld_next;
    logic                 iss_use_reg, iss_use_next;
    mac_ctrl_t            mac_ctrl;
    logic                 mac_busy;
    logic signed [SAMPLE_W-1:0] mac_result;

    logic                 dl_wr_en;
    logic [DL_AW-1:0]     dl_wr_addr;
    logic [DL_AW-1:0]     dl_rd_addr;
    logic                 rd_en;
    logic signed [SAMPLE_W-1:0] dl_rd_data;
    logic signed [SAMPLE_W-1:0] coef_rd_data;

    logic                 out_load;
    logic                 out_vld_reg;
    logic [CH_W-1:0]      out_chan_reg;
    logic signed [VALUE_W-1:0] out_sample_reg;
    logic                 out_last_reg;

    mcfir_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tap_count (tap_count)
    );

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    assign accept    = item.valid && item.ready;
    assign item_chan = CH_IDX_W'(item.channel);
    assign chan_ok   = int'(item.channel) < CHANNELS;
    assign tap_ok    = int'(item.tap_index) < TAPS;
    assign filt_go   = accept && (item.opcode == OP_FILTER) && chan_ok;
    assign coef_wr   = accept && (item.opcode == OP_COEF) && tap_ok;

    assign ptr_inc  = (ptr_reg[item_chan] == TAP_W'(TAPS - 1)) ? '0
                                                             : ptr_reg[item_chan] + 1'b1;
    assign fill_inc = (fill_reg[item_chan] == TAP_CNT_W'(TAPS)) ? fill_reg[item_chan]
                                                               : fill_reg[item_chan] + 1'b1;
    assign n_eff    = (int'(tap_count) > TAPS) ? TAP_CNT_W'(TAPS) : TAP_CNT_W'(tap_count);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    assign dl_wr_en   = filt_go;
    assign dl_wr_addr = DL_AW'(item_chan) * DL_AW'(TAPS) + DL_AW'(ptr_inc);

    // Tap k of the delay line sits k places behind the newest sample.
    assign kidx   = k_reg[TAP_W-1:0];
    assign rd_idx = (ptr_cur_reg >= kidx) ? ptr_cur_reg - kidx
                                          : ptr_cur_reg + TAP_W'(TAPS) - kidx;
    assign dl_rd_addr = DL_AW'(chan_reg) * DL_AW'(TAPS) + DL_AW'(rd_idx);
    assign rd_en      = (state_reg == S_RUN);

    mcfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DL_DEPTH)
    ) u_dl_ram (
        .clk     (clk),
        .wr_en   (dl_wr_en),
        .wr_addr (dl_wr_addr),
        .wr_data (SAMPLE_W'(item.value)),
        .rd_en   (rd_en),
        .rd_addr (dl_rd_addr),
        .rd_data (dl_rd_data)
    );

    mcfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (TAP_W'(item.tap_index)),
        .wr_data (SAMPLE_W'(item.value)),
        .rd_en   (rd_en),
        .rd_addr (kidx),
        .rd_data (coef_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptr_reg[c]  <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            if (coef_wr)
            begin
                coef_vld_reg[TAP_W'(item.tap_index)] <= 1'b1;
            end
            if (filt_go)
            begin
                ptr_reg[item_chan]  <= ptr_inc;
                fill_reg[item_chan] <= fill_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        item.ready   = 1'b0;
        out_load     = 1'b0;
        iss_vld_next = 1'b0;
        iss_use_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                k_next     = '0;
                if (filt_go)
                begin
                    state_next = (n_eff == '0) ? S_ROUND : S_RUN;
                end
            end
            S_RUN:
            begin
                iss_vld_next = 1'b1;
                iss_use_next = (k_reg < fill_cur_reg) && coef_vld_reg[kidx];
                k_next       = k_reg + 1'b1;
                if (k_reg == n_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!iss_vld_reg && !mac_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            iss_vld_reg <= 1'b0;
            iss_use_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            iss_vld_reg <= iss_vld_next;
            iss_use_reg <= iss_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (filt_go)
        begin
            chan_reg     <= item_chan;
            chan_out_reg <= item.channel;
            last_reg     <= item.last_in_hop;
            ptr_cur_reg  <= ptr_inc;
            fill_cur_reg <= fill_inc;
            n_reg        <= n_eff;
        end
    end

    always_comb
    begin
        mac_ctrl.clear    = filt_go;
        mac_ctrl.vld      = iss_vld_reg;
        mac_ctrl.use_data = iss_use_reg;
    end

    mcfir_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (dl_rd_data),
        .coef   (coef_rd_data),
        .busy   (mac_busy),
        .result (mac_result)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_chan_reg   <= chan_out_reg;
            out_sample_reg <= VALUE_W'(mac_result);
            out_last_reg   <= last_reg;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.out_channel     = out_chan_reg;
    assign result.filtered_sample = out_sample_reg;
    assign result.out_last_in_hop = out_last_reg;

`ifndef ASSERT_OFF
    // A fill count never passes the delay line length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (int'(fill_cur_reg) <= TAPS))
        else $error("fill count beyond delay line length");

    // Taps are issued only below the active tap count.
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (k_reg < n_reg))
        else $error("tap counter beyond active tap count");

    // Read data reaches the MAC only after an issue in the tap loop.
    a_iss_state: assert property (@(posedge clk) disable iff (!rst_n)
        iss_vld_reg |-> ((state_reg == S_RUN) || (state_reg == S_DRAIN)))
        else $error("MAC fed outside the tap loop");

    // Rounding only starts once the MAC pipeline is empty.
    a_round_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (!iss_vld_reg && !mac_busy))
        else $error("rounding with products still in flight");
`endif

endmodule

[hw/rtl/mcfir_ram.sv]
// ----------------------------------------------------------------------------
// mcfir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mcfir_cfg.sv]
// ----------------------------------------------------------------------------
// mcfir_cfg
// APB-style configuration register file holding the active tap count.
// ----------------------------------------------------------------------------
module mcfir_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcfir_pkg::PADDR_W-1:0] paddr,
    input  logic [mcfir_pkg::PDATA_W-1:0] pwdata,
    output logic [mcfir_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [mcfir_pkg::CFG_W-1:0]  tap_count
);
    import mcfir_pkg::*;

    logic [CFG_W-1:0]  tap_count_reg;
    logic [CFG_W-1:0]  tap_count_next;
    logic [RIDX_W-1:0] reg_idx;
    logic              wr_xfer;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite && pready;

    always_comb
    begin
        tap_count_next = tap_count_reg;
        if (wr_xfer && (reg_idx == REG_TAP_COUNT))
        begin
            tap_count_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else
        begin
            tap_count_reg <= tap_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_TAP_COUNT)
        begin
            prdata = PDATA_W'(tap_count_reg);
        end
    end

    assign tap_count = tap_count_reg;

endmodule

[hw/rtl/mcfir_mac.sv]
// ----------------------------------------------------------------------------
// mcfir_mac
// Shared multiply-accumulate unit with round-half-up and saturation.
// ----------------------------------------------------------------------------
module mcfir_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcfir_pkg::mac_ctrl_t                ctrl,
    input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [mcfir_pkg::SAMPLE_W-1:0] coef,
    output logic                                busy,
    output logic signed [mcfir_pkg::SAMPLE_W-1:0] result
);
    import mcfir_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (SAMPLE_W - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  shifted;

    always_comb
    begin
        prod_next = '0;
        if (ctrl.use_data)
        begin
            prod_next = sample * coef;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Floor of (acc + half LSB) / 2^(SAMPLE_W-1), clamped to the sample range.
    always_comb
    begin
        rnd_sum = acc_reg + HALF;
        shifted = rnd_sum >>> (SAMPLE_W - 1);
        priority if (shifted > SAT_HI)
        begin
            result = SAMPLE_W'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            result = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            result = SAMPLE_W'(shifted);
        end
    end

    assign busy = prod_vld_reg;

endmodule

[test/tb_multichannel_fir_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_fir_filter
// Self-checking testbench for the multichannel FIR filter. A behavioural
// copy of the filter keeps its own delay lines, coefficients and tap count,
// predicts every filtered sample and compares it field by field with what
// the block delivers. Directed cases cover the field extremes, both
// operations and the tap count limits. Random hops and coefficient loads
// then run under several tap counts, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_multichannel_fir_filter;
    import mcfir_pkg::*;

    localparam int SETTLE_CYCLES = 2 * (TAPS + 4);

    typedef struct {
        opcode_t                   op;
        logic [CH_W-1:0]           ch;
        logic [TIDX_W-1:0]         idx;
        logic signed [VALUE_W-1:0] val;
        logic                      last;
    } fir_item_t;

    typedef struct {
        logic [CH_W-1:0]           ch;
        logic signed [VALUE_W-1:0] sample;
        logic                      last;
    } fir_output_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    mcfir_item_if   item_bus ();
    mcfir_result_if result_bus ();

    multichannel_fir_filter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the filter state
    logic signed [VALUE_W-1:0] history [CHANNELS][TAPS];
    logic signed [VALUE_W-1:0] coef_set [TAPS];
    logic [CFG_W-1:0]          active_taps;

    fir_output_t awaited_outputs [$];
    int          errors;
    bit          no_gaps;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("[multichannel_fir_filter] ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 45);
    endfunction

    function automatic logic signed [VALUE_W-1:0] sample_word();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return VALUE_W'($urandom_range(0, 511)) - 16'sd256;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] coef_word();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3, 4, 5: return VALUE_W'($urandom_range(0, 4095)) - 16'sd2048;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Stores a loaded coefficient, or shifts a sample into its channel, sums the
    // active taps at full width, then rounds half up and saturates to Q1.15.
    function automatic void run_fir_item(input fir_item_t it);
        longint      acc;
        longint      y;
        int          n;
        fir_output_t o;
        if (it.op == OP_COEF)
        begin
            if (it.idx < TAPS)
                coef_set[it.idx] = it.val;
            return;
        end
        if (it.ch >= CHANNELS)
            return;
        for (int k = TAPS - 1; k > 0; k--)
            history[it.ch][k] = history[it.ch][k - 1];
        history[it.ch][0] = it.val;
        n = (active_taps > TAPS) ? TAPS : int'(active_taps);
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(coef_set[k]) * longint'(history[it.ch][k]);
        y = (acc + (longint'(1) <<< (SAMPLE_W - 2))) >>> (SAMPLE_W - 1);
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        o.ch     = it.ch;
        o.sample = y[VALUE_W-1:0];
        o.last   = it.last;
        awaited_outputs.push_back(o);
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transfer with valid still high, so back-to-back items need no gap.
    task automatic send_item(input opcode_t op, input int ch, input int idx,
                             input logic signed [VALUE_W-1:0] val, input bit last);
        fir_item_t it;
        int        gap;
        gap = gap_len();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        it.op   = op;
        it.ch   = CH_W'(ch);
        it.idx  = TIDX_W'(idx);
        it.val  = val;
        it.last = last;
        item_bus.opcode      <= it.op;
        item_bus.channel     <= it.ch;
        item_bus.tap_index   <= it.idx;
        item_bus.value       <= it.val;
        item_bus.last_in_hop <= it.last;
        item_bus.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        run_fir_item(it);
        @(negedge clk);
    endtask

    task automatic send_sample(input int ch, input logic signed [VALUE_W-1:0] val,
                               input bit last);
        send_item(OP_FILTER, ch, $urandom_range(0, 31), val, last);
    endtask

    task automatic send_coef(input int idx, input logic signed [VALUE_W-1:0] val);
        send_item(OP_COEF, $urandom_range(0, 7), idx, val, 1'($urandom_range(0, 1)));
    endtask

    // Stops the sender and waits until every filtered sample is in, plus the
    // time a trailing coefficient load or sample could still be in flight.
    task automatic wait_outputs_drained();
        item_bus.valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_transfer(input bit wr, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_TAP_COUNT, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            active_taps = wdata[CFG_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_tap_count(input int count);
        logic [PDATA_W-1:0] rd;
        wait_outputs_drained();
        cfg_transfer(1'b1, PDATA_W'(count), rd);
        @(negedge clk);
        cfg_transfer(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== active_taps)
        begin
            $error("tap_count: expected %0d, actual %0d", active_taps, rd[CFG_W-1:0]);
            errors++;
        end
        @(negedge clk);
    endtask

    task automatic test_reset_state();
        logic [PDATA_W-1:0] rd;
        cfg_transfer(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== TAP_COUNT_RESET)
        begin
            $error("tap_count: expected %0d, actual %0d", TAP_COUNT_RESET, rd[CFG_W-1:0]);
            errors++;
        end
        @(negedge clk);
        // All coefficients are still zero, so extremes filter to zero.
        send_sample(0, 16'sh7FFF, 1'b0);
        send_sample(7, 16'sh8000, 1'b1);
    endtask

    task automatic test_saturation();
        set_tap_count(1);
        send_coef(0, 16'sh8000);
        send_sample(1, 16'sh8000, 1'b0);
        send_sample(1, 16'sh7FFF, 1'b0);
        send_sample(1, 16'sh0001, 1'b0);
        send_sample(1, 16'sh0000, 1'b1);
        set_tap_count(2);
        send_coef(1, 16'sh8000);
        send_sample(2, 16'sh7FFF, 1'b0);
        send_sample(2, 16'sh7FFF, 1'b1);
    endtask

    task automatic test_tap_count_limits();
        set_tap_count(63);
        send_coef(31, 16'sh7FFF);
        send_sample(3, 16'sh4000, 1'b1);
        set_tap_count(0);
        send_sample(4, 16'sh7FFF, 1'b1);
        set_tap_count(33);
        send_sample(5, 16'sh8000, 1'b0);
    endtask

    task automatic test_channels_and_hops();
        set_tap_count(32);
        for (int c = 0; c < CHANNELS; c++)
            send_sample(c, (c % 2 == 0) ? 16'sh7FFF : 16'sh8000, 1'(c % 2));
    endtask

    task automatic random_traffic(input int budget, input bit pause_midway);
        int  sent;
        int  ch;
        int  hop;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < budget)
        begin
            if (pause_midway && !paused && sent >= budget / 2)
            begin
                wait_outputs_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_coef($urandom_range(0, 31), coef_word());
                    sent++;
                end
            end
            else
            begin
                ch  = $urandom_range(0, CHANNELS - 1);
                hop = $urandom_range(1, 8);
                // Most hops end on their last sample; a few carry stray marks.
                if ($urandom_range(0, 9) == 0)
                begin
                    for (int h = 0; h < hop; h++)
                        send_sample($urandom_range(0, CHANNELS - 1), sample_word(),
                                    1'($urandom_range(0, 1)));
                end
                else
                begin
                    for (int h = 0; h < hop; h++)
                        send_sample(ch, sample_word(), h == hop - 1);
                end
                sent += hop;
            end
        end
    endtask

    task automatic test_random_phases();
        int counts [7];
        counts = '{32, 1, 63, 0, 17, 33, 0};
        counts[6] = $urandom_range(2, 31);
        for (int p = 0; p < 7; p++)
        begin
            set_tap_count(counts[p]);
            no_gaps = (p == 2);
            random_traffic(85, p == 4);
        end
        no_gaps = 1'b0;
    endtask

    // Result checker: each transfer is compared with the oldest prediction.
    always @(posedge clk)
    begin
        fir_output_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                $error("filtered_sample: no result expected, actual %0d",
                       result_bus.filtered_sample);
                errors++;
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (result_bus.out_channel !== want.ch)
                begin
                    $error("out_channel: expected %0d, actual %0d",
                           want.ch, result_bus.out_channel);
                    errors++;
                end
                if (result_bus.filtered_sample !== want.sample)
                begin
                    $error("filtered_sample: expected %0d, actual %0d",
                           want.sample, result_bus.filtered_sample);
                    errors++;
                end
                if (result_bus.out_last_in_hop !== want.last)
                begin
                    $error("out_last_in_hop: expected %0d, actual %0d",
                           want.last, result_bus.out_last_in_hop);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: runs of ready with occasional gaps, none in steady phases.
    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !no_gaps)
            begin
                result_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    initial
    begin
        errors                = 0;
        no_gaps               = 1'b0;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_bus.valid        = 1'b0;
        item_bus.opcode       = OP_FILTER;
        item_bus.channel      = '0;
        item_bus.tap_index    = '0;
        item_bus.value        = '0;
        item_bus.last_in_hop  = 1'b0;
        active_taps           = TAP_COUNT_RESET;
        for (int c = 0; c < CHANNELS; c++)
            for (int k = 0; k < TAPS; k++)
                history[c][k] = '0;
        for (int k = 0; k < TAPS; k++)
            coef_set[k] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_saturation();
        test_tap_count_limits();
        test_channels_and_hops();
        test_random_phases();

        wait_outputs_drained();
        if (errors == 0)
            $display("[multichannel_fir_filter] OK");
        else
            $display("[multichannel_fir_filter] ERROR");
        $finish;
    end

endmodule

[multichannel_fir_filter.f]
hw/rtl/mcfir_pkg.sv
hw/rtl/mcfir_item_if.sv
hw/rtl/mcfir_result_if.sv
hw/rtl/mcfir_ram.sv
hw/rtl/mcfir_cfg.sv
hw/rtl/mcfir_mac.sv
hw/rtl/multichannel_fir_filter.sv
test/tb_multichannel_fir_filter.sv
